// ===== sv/stbf_pkg.sv =====
// Shared types and constants for the scrolled tile background fetch block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package stbf_pkg;

  localparam int CMD_W       = 2;
  localparam int MEM_ADDR_W  = 13;
  localparam int NT_ADDR_W   = 11;
  localparam int NT_DEPTH    = 2048;
  localparam int PAT_DEPTH   = 8192;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int HASH_W      = 64;

  // Rows added above the visible area before the world lookup.
  localparam logic [8:0] TOP_CROP   = 9'd8;
  // World height and the pixel height of one nametable.
  localparam logic [9:0] WORLD_H    = 10'd480;
  localparam logic [9:0] NT_SPAN_Y  = 10'd240;
  localparam logic [5:0] NT_TILES_Y = 6'd30;

  // FNV-1a 64; the prime is 2^40 + 0x1B3.
  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = 64'h1B3;
  localparam int                FNV_PRIME_SH = 40;

  localparam logic [4:0] PAT_BYTES = 5'd16;

  typedef enum logic [1:0] {
    CMD_NT_WR   = 2'd0,
    CMD_PAT_WR  = 2'd1,
    CMD_PIX_Q   = 2'd2,
    CMD_CELL_Q  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MIR_SINGLE_LO = 2'd0,
    MIR_SINGLE_HI = 2'd1,
    MIR_VERT      = 2'd2,
    MIR_HORZ      = 2'd3
  } mirror_t;

  typedef enum logic [1:0] {
    REG_SCROLL   = 2'd0,
    REG_FINE_X   = 2'd1,
    REG_MIRROR   = 2'd2,
    REG_PAT_HIGH = 2'd3
  } reg_idx_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CELL  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TILE,
    S_PIX,
    S_HASH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [14:0] scroll_addr;
    logic [2:0]  fine_x;
    mirror_t     mirror;
    logic        pat_high;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/stbf_if.sv =====
// Valid/ready channel interfaces for query items and result items.
// Depends on stbf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stbf_in_if;
  import stbf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [MEM_ADDR_W-1:0] mem_addr;
  logic [7:0]            mem_data;
  logic [7:0]            pixel_x;
  logic [7:0]            pixel_row;
  logic [4:0]            cell_col;
  logic [4:0]            cell_row;

  modport source (
    output valid, cmd, mem_addr, mem_data, pixel_x, pixel_row, cell_col, cell_row,
    input  ready
  );
  modport sink (
    input  valid, cmd, mem_addr, mem_data, pixel_x, pixel_row, cell_col, cell_row,
    output ready
  );
endinterface

interface stbf_out_if;
  import stbf_pkg::*;

  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [1:0]        pattern_pixel;
  logic [7:0]        tile_id;
  logic [HASH_W-1:0] pattern_hash;

  modport source (
    output valid, result_kind, pattern_pixel, tile_id, pattern_hash,
    input  ready
  );
  modport sink (
    input  valid, result_kind, pattern_pixel, tile_id, pattern_hash,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/scrolled_tile_background_fetch.sv =====
// Scrolled tile background fetch: nametable and pattern RAMs, pixel and cell queries.
// Writes go to the RAMs on accept. Pixel query: nametable read, then both pattern rows
// in S_TILE, then S_PIX. Cell query: 16 pattern bytes fed one per cycle through the FNV
// step in S_HASH, then S_OUT. Results sit in an output register; the next item is taken
// once the sequencer is back in idle. rst_n (sync, active low) clears control state and
// config registers; RAM contents are undefined until written, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scrolled_tile_background_fetch (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  stbf_in_if.sink                               in_chan,
  stbf_out_if.source                            out_chan,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [stbf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [stbf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [stbf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import stbf_pkg::*;

  cfg_t cfg;

  stbf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cmd_t                 in_cmd;
  logic                 in_fire;
  logic                 is_query;
  logic [NT_ADDR_W-1:0] nt_raddr;
  logic [2:0]           fine_x;
  logic [2:0]           fine_y;

  assign in_cmd   = cmd_t'(in_chan.cmd);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign is_query = (in_cmd == CMD_PIX_Q) || (in_cmd == CMD_CELL_Q);

  stbf_coord u_coord (
    .cfg       (cfg),
    .is_cell   (in_cmd == CMD_CELL_Q),
    .pixel_x   (in_chan.pixel_x),
    .pixel_row (in_chan.pixel_row),
    .cell_col  (in_chan.cell_col),
    .cell_row  (in_chan.cell_row),
    .nt_addr   (nt_raddr),
    .fine_x    (fine_x),
    .fine_y    (fine_y)
  );

  // sequencer state
  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       kind_r;
  logic [2:0] fx_r;
  logic [2:0] fy_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [1:0] out_pix_r, out_pix_nxt;
  logic [7:0] out_tile_r, out_tile_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;

  // memory controls
  logic                  nt_we, nt_re, pat_we, pat_re;
  logic [MEM_ADDR_W-1:0] pat_addr_a, pat_addr_b;
  logic [7:0]            nt_q_r;
  logic [7:0]            pat_qa_r, pat_qb_r;
  logic [7:0]            nt_ram  [NT_DEPTH];
  logic [7:0]            pat_ram [PAT_DEPTH];

  logic              fnv_init, fnv_step;
  logic [HASH_W-1:0] fnv_hash;
  logic              out_free;
  logic              out_load;
  logic [2:0]        bit_sel;

  assign out_free = !out_valid_r || out_chan.ready;
  assign bit_sel  = 3'd7 - fx_r;

  stbf_fnv u_fnv (
    .clk  (clk),
    .init (fnv_init),
    .step (fnv_step),
    .data (pat_qa_r),
    .hash (fnv_hash)
  );

  always_ff @(posedge clk) begin
    if (nt_we) begin
      nt_ram[in_chan.mem_addr[NT_ADDR_W-1:0]] <= in_chan.mem_data;
    end
    if (nt_re) begin
      nt_q_r <= nt_ram[nt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_ram[in_chan.mem_addr] <= in_chan.mem_data;
    end
    if (pat_re) begin
      pat_qa_r <= pat_ram[pat_addr_a];
      pat_qb_r <= pat_ram[pat_addr_b];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire && is_query) state_nxt = S_TILE;
      S_TILE: state_nxt = (kind_r == KIND_CELL) ? S_HASH : S_PIX;
      S_PIX:  if (out_free) state_nxt = S_IDLE;
      S_HASH: if (cnt_r == PAT_BYTES) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    nt_we      = 1'b0;
    nt_re      = 1'b0;
    pat_we     = 1'b0;
    pat_re     = 1'b0;
    pat_addr_a = {cfg.pat_high, nt_q_r, 4'd0};
    pat_addr_b = {cfg.pat_high, nt_q_r, 4'd0};
    fnv_init   = 1'b0;
    fnv_step   = 1'b0;
    out_load   = 1'b0;
    cnt_nxt    = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        nt_we  = in_fire && (in_cmd == CMD_NT_WR);
        pat_we = in_fire && (in_cmd == CMD_PAT_WR);
        nt_re  = in_fire && is_query;
      end
      S_TILE: begin
        pat_re = 1'b1;
        if (kind_r == KIND_CELL) begin
          fnv_init = 1'b1;
          cnt_nxt  = 5'd1;
        end else begin
          // low plane row, then high plane row eight bytes on
          pat_addr_a = {cfg.pat_high, nt_q_r, 1'b0, fy_r};
          pat_addr_b = {cfg.pat_high, nt_q_r, 1'b1, fy_r};
        end
      end
      S_HASH: begin
        // byte cnt-1 arrives while byte cnt is fetched
        fnv_step   = 1'b1;
        pat_re     = (cnt_r != PAT_BYTES);
        pat_addr_a = {cfg.pat_high, nt_q_r, cnt_r[3:0]};
        cnt_nxt    = cnt_r + 5'd1;
      end
      S_PIX:   out_load = out_free;
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_pix_nxt   = out_pix_r;
    out_tile_nxt  = out_tile_r;
    out_hash_nxt  = out_hash_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (kind_r == KIND_CELL) begin
        out_kind_nxt = KIND_CELL;
        out_pix_nxt  = 2'd0;
        out_tile_nxt = nt_q_r;
        out_hash_nxt = fnv_hash;
      end else begin
        out_kind_nxt = KIND_PIXEL;
        out_pix_nxt  = {pat_qb_r[bit_sel], pat_qa_r[bit_sel]};
        out_tile_nxt = 8'd0;
        out_hash_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      kind_r <= (in_cmd == CMD_CELL_Q) ? KIND_CELL : KIND_PIXEL;
      fx_r   <= fine_x;
      fy_r   <= fine_y;
    end
    out_kind_r <= out_kind_nxt;
    out_pix_r  <= out_pix_nxt;
    out_tile_r <= out_tile_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_kind   = out_kind_r;
  assign out_chan.pattern_pixel = out_pix_r;
  assign out_chan.tile_id       = out_tile_r;
  assign out_chan.pattern_hash  = out_hash_r;

endmodule

`default_nettype wire

// ===== sv/stbf_cfg_regs.sv =====
// APB-style configuration registers: scroll address, fine X, mirroring, pattern table.
// Depends on stbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stbf_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [stbf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [stbf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [stbf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output stbf_pkg::cfg_t                        cfg
);
  import stbf_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SCROLL:   cfg_nxt.scroll_addr = pwdata[14:0];
        REG_FINE_X:   cfg_nxt.fine_x      = pwdata[2:0];
        REG_MIRROR:   cfg_nxt.mirror      = mirror_t'(pwdata[1:0]);
        REG_PAT_HIGH: cfg_nxt.pat_high    = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCROLL:   prdata = {17'd0, cfg_r.scroll_addr};
      REG_FINE_X:   prdata = {29'd0, cfg_r.fine_x};
      REG_MIRROR:   prdata = {30'd0, cfg_r.mirror};
      REG_PAT_HIGH: prdata = {31'd0, cfg_r.pat_high};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scroll_addr: 15'd0, fine_x: 3'd0, mirror: MIR_SINGLE_LO, pat_high: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stbf_coord.sv =====
// Scrolled world coordinate and mirrored nametable address for a query item.
// Depends on stbf_pkg (cfg_t, world constants).
`timescale 1ns / 1ps
`default_nettype none

module stbf_coord (
  input  wire stbf_pkg::cfg_t                  cfg,
  input  wire logic                            is_cell,
  input  wire logic [7:0]                      pixel_x,
  input  wire logic [7:0]                      pixel_row,
  input  wire logic [4:0]                      cell_col,
  input  wire logic [4:0]                      cell_row,
  output logic      [stbf_pkg::NT_ADDR_W-1:0]  nt_addr,
  output logic      [2:0]                      fine_x,
  output logic      [2:0]                      fine_y
);
  import stbf_pkg::*;

  logic [8:0]  scr_x;
  logic [9:0]  scr_y;
  logic [7:0]  qx;
  logic [8:0]  qy;
  logic [8:0]  wx;
  logic [9:0]  sum_y;
  logic [8:0]  wy;
  logic [5:0]  tx;
  logic [5:0]  ty;
  logic        ty_hi;
  logic [5:0]  ty_mod;
  logic [11:0] logical;

  // 256*ntX + 8*coarseX + fineX is a plain concatenation
  assign scr_x = {cfg.scroll_addr[10], cfg.scroll_addr[4:0], cfg.fine_x};
  assign scr_y = (cfg.scroll_addr[11] ? NT_SPAN_Y : 10'd0)
               + {2'd0, cfg.scroll_addr[9:5], cfg.scroll_addr[14:12]};

  assign qx = is_cell ? {cell_col, 3'd4} : pixel_x;
  assign qy = (is_cell ? {1'b0, cell_row, 3'd4} : {1'b0, pixel_row}) + TOP_CROP;

  assign wx    = scr_x + {1'b0, qx};
  assign sum_y = scr_y + {1'b0, qy};
  // sum stays below twice the world height
  assign wy    = (sum_y >= WORLD_H) ? 9'(sum_y - WORLD_H) : sum_y[8:0];

  assign tx     = wx[8:3];
  assign ty     = wy[8:3];
  assign ty_hi  = (ty >= NT_TILES_Y);
  assign ty_mod = ty_hi ? (ty - NT_TILES_Y) : ty;

  assign logical = {ty_hi, tx[5], ty_mod[4:0], tx[4:0]};

  always_comb begin
    case (cfg.mirror)
      MIR_SINGLE_LO: nt_addr = {1'b0, logical[9:0]};
      MIR_SINGLE_HI: nt_addr = {1'b1, logical[9:0]};
      MIR_VERT:      nt_addr = logical[10:0];
      MIR_HORZ:      nt_addr = {logical[11], logical[9:0]};
      default:       nt_addr = logical[10:0];
    endcase
  end

  assign fine_x = wx[2:0];
  assign fine_y = wy[2:0];

endmodule

`default_nettype wire

// ===== sv/stbf_fnv.sv =====
// FNV-1a 64 accumulator, one byte per cycle while step is high.
// Depends on stbf_pkg for the basis and prime split.
`timescale 1ns / 1ps
`default_nettype none

module stbf_fnv (
  input  wire logic                         clk,
  input  wire logic                         init,
  input  wire logic                         step,
  input  wire logic [7:0]                   data,
  output logic      [stbf_pkg::HASH_W-1:0]  hash
);
  import stbf_pkg::*;

  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] prod_lo;

  assign mixed   = hash_r ^ {{(HASH_W-8){1'b0}}, data};
  // constant multiplier by 0x1B3 reduces to a few adds
  assign prod_lo = HASH_W'(mixed * FNV_PRIME_LO);

  always_comb begin
    hash_nxt = hash_r;
    if (init) begin
      hash_nxt = FNV_BASIS;
    end else if (step) begin
      hash_nxt = (mixed << FNV_PRIME_SH) + prod_lo;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

  assign hash = hash_r;

endmodule

`default_nettype wire

// ===== tb/stbf_tb_pkg.sv =====
// Testbench-side addressing helpers and item/result types for the background fetch bench.
// Depends on stbf_pkg; shared by the checker and the stimulus top.
`timescale 1ns / 1ps

package stbf_tb_pkg;
  import stbf_pkg::*;

  localparam logic [63:0] FNV64_OFFSET  = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV64_PRIME   = 64'h00000100000001B3;
  localparam int unsigned CROP_ROWS     = 8;
  localparam int unsigned PAT_HIGH_BASE = 4096;

  typedef struct packed {
    cmd_t        cmd;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [7:0]  px;
    logic [7:0]  prow;
    logic [4:0]  ccol;
    logic [4:0]  crow;
  } fetch_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  pix;
    logic [7:0]  tile;
    logic [63:0] hash;
  } fetch_result_t;

  // Screen offset to world position; the world wraps at 512 x 480.
  function automatic int unsigned world_x(cfg_t c, int unsigned off);
    return (256 * c.scroll_addr[10] + 8 * c.scroll_addr[4:0] + c.fine_x + off) % 512;
  endfunction

  function automatic int unsigned world_y(cfg_t c, int unsigned off);
    return (240 * c.scroll_addr[11] + 8 * c.scroll_addr[9:5] + c.scroll_addr[14:12] + off)
           % 480;
  endfunction

  // Physical nametable byte holding the tile under a world position.
  function automatic int unsigned nt_slot(cfg_t c, int unsigned wx, int unsigned wy);
    int unsigned tx, ty, logical;
    tx = wx / 8;
    ty = wy / 8;
    logical = ((ty / 30) % 2) * 2048 + ((tx / 32) % 2) * 1024 + (ty % 30) * 32 + tx % 32;
    case (c.mirror)
      MIR_SINGLE_LO: return logical % 1024;
      MIR_SINGLE_HI: return logical % 1024 + 1024;
      MIR_VERT:      return logical % 2048;
      default:       return ((logical / 2) & 1024) | (logical % 1024);
    endcase
  endfunction

  function automatic int unsigned pat_addr(cfg_t c, int unsigned tile, int unsigned i);
    return (c.pat_high ? PAT_HIGH_BASE : 0) + tile * 16 + i;
  endfunction

  // Pixel queries look at the given pixel, cell queries at the cell centre.
  function automatic void query_spot(input cfg_t c, input fetch_item_t it,
                                     output int unsigned wx, output int unsigned wy);
    if (it.cmd == CMD_PIX_Q) begin
      wx = world_x(c, it.px);
      wy = world_y(c, it.prow + CROP_ROWS);
    end else begin
      wx = world_x(c, 8 * it.ccol + 4);
      wy = world_y(c, 8 * it.crow + 4 + CROP_ROWS);
    end
  endfunction

endpackage

// ===== tb/stbf_checker.sv =====
// Checker for the background fetch block: tracks config writes and RAM writes, predicts
// each query result and compares it with the output channel. Depends on stbf_tb_pkg.
`timescale 1ns / 1ps

module stbf_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  stbf_in_if                                  in_chan,
  stbf_out_if                                 out_chan,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [stbf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [stbf_pkg::CFG_DATA_W-1:0]     pwdata,
  output int                                  errors,
  output int                                  pending,
  output int                                  checked
);
  import stbf_pkg::*;
  import stbf_tb_pkg::*;

  logic [7:0]    nt_mem  [NT_DEPTH];
  logic [7:0]    pat_mem [PAT_DEPTH];
  cfg_t          cfg;
  fetch_result_t pending_fetches[$];
  int            err_cnt  = 0;
  int            pend_cnt = 0;
  int            chk_cnt  = 0;

  assign errors  = err_cnt;
  assign pending = pend_cnt;
  assign checked = chk_cnt;

  function automatic fetch_result_t background_fetch(fetch_item_t it);
    fetch_result_t r;
    int unsigned   wx, wy, tile, bitpos;
    logic [7:0]    lo, hi;
    r = '0;
    query_spot(cfg, it, wx, wy);
    tile = nt_mem[nt_slot(cfg, wx, wy)];
    if (it.cmd == CMD_PIX_Q) begin
      bitpos = 7 - wx % 8;
      lo = pat_mem[pat_addr(cfg, tile, wy % 8)];
      hi = pat_mem[pat_addr(cfg, tile, wy % 8 + 8)];
      r.kind = KIND_PIXEL;
      r.pix  = {hi[bitpos], lo[bitpos]};
    end else begin
      r.kind = KIND_CELL;
      r.tile = 8'(tile);
      r.hash = FNV64_OFFSET;
      for (int i = 0; i < 16; i++)
        r.hash = (r.hash ^ pat_mem[pat_addr(cfg, tile, i)]) * FNV64_PRIME;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    fetch_item_t   it;
    fetch_result_t got, want;
    if (!rst_n) begin
      cfg = '0;
      pending_fetches.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SCROLL:   cfg.scroll_addr = pwdata[14:0];
          REG_FINE_X:   cfg.fine_x      = pwdata[2:0];
          REG_MIRROR:   cfg.mirror      = mirror_t'(pwdata[1:0]);
          REG_PAT_HIGH: cfg.pat_high    = pwdata[0];
          default: ;
        endcase
      end

      if (out_chan.valid && out_chan.ready) begin
        got.kind = out_chan.result_kind;
        got.pix  = out_chan.pattern_pixel;
        got.tile = out_chan.tile_id;
        got.hash = out_chan.pattern_hash;
        if (pending_fetches.size() == 0) begin
          report_mismatch("result with no query outstanding", got.kind, 0);
        end else begin
          want = pending_fetches.pop_front();
          chk_cnt++;
          if (got.kind != want.kind) report_mismatch("result_kind", got.kind, want.kind);
          if (got.pix != want.pix)   report_mismatch("pattern_pixel", got.pix, want.pix);
          if (got.tile != want.tile) report_mismatch("tile_id", got.tile, want.tile);
          if (got.hash != want.hash) report_mismatch("pattern_hash", got.hash, want.hash);
        end
      end

      if (in_chan.valid && in_chan.ready) begin
        it.cmd  = cmd_t'(in_chan.cmd);
        it.addr = in_chan.mem_addr;
        it.data = in_chan.mem_data;
        it.px   = in_chan.pixel_x;
        it.prow = in_chan.pixel_row;
        it.ccol = in_chan.cell_col;
        it.crow = in_chan.cell_row;
        case (it.cmd)
          CMD_NT_WR:  nt_mem[it.addr[10:0]] = it.data;
          CMD_PAT_WR: pat_mem[it.addr] = it.data;
          default:    pending_fetches.push_back(background_fetch(it));
        endcase
      end
    end
    pend_cnt <= pending_fetches.size();
  end

endmodule

// ===== tb/tb_scrolled_tile_background_fetch.sv =====
// Top of the background fetch bench: clock, reset, register writes and item stimulus.
// Depends on stbf_pkg, stbf_tb_pkg, the channel interfaces and stbf_checker.
`timescale 1ns / 1ps

module tb_scrolled_tile_background_fetch;
  import stbf_pkg::*;
  import stbf_tb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  accept_out = 1'b0;
  int                    errors, pending, checked;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    n_items = 0;
  int                    n_pix = 0;
  int                    n_cell = 0;
  cfg_t                  cfg;
  logic [7:0]            nt_shadow  [NT_DEPTH];
  bit                    nt_loaded  [NT_DEPTH];
  bit                    pat_loaded [PAT_DEPTH];

  stbf_in_if  in_chan();
  stbf_out_if out_chan();

  scrolled_tile_background_fetch DUT (
    .clk, .rst_n, .in_chan(in_chan), .out_chan(out_chan),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stbf_checker u_check (
    .clk, .rst_n, .in_chan(in_chan), .out_chan(out_chan),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .checked
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign out_chan.ready = accept_out;

  always @(posedge clk) begin
    accept_out <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("timed out, %0d results outstanding", pending);
    $display("FAIL scrolled_tile_background_fetch");
    $finish;
  end

  function automatic fetch_item_t random_item(cmd_t c);
    fetch_item_t it;
    it.cmd  = c;
    it.addr = 13'($urandom);
    it.data = 8'($urandom);
    it.px   = 8'($urandom);
    it.prow = 8'($urandom);
    it.ccol = 5'($urandom);
    it.crow = 5'($urandom);
    return it;
  endfunction

  // Tile ids mostly from a small pool so pattern bytes get reused by cell queries.
  function automatic int unsigned pick_tile();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(255);
      3:       return 255;
      default: return $urandom_range(7);
    endcase
  endfunction

  task automatic push_item(fetch_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= it.cmd;
    in_chan.mem_addr  <= it.addr;
    in_chan.mem_data  <= it.data;
    in_chan.pixel_x   <= it.px;
    in_chan.pixel_row <= it.prow;
    in_chan.cell_col  <= it.ccol;
    in_chan.cell_row  <= it.crow;
    do @(posedge clk); while (!in_chan.ready);
    n_items++;
    case (it.cmd)
      CMD_NT_WR: begin
        nt_shadow[it.addr[10:0]] = it.data;
        nt_loaded[it.addr[10:0]] = 1'b1;
      end
      CMD_PAT_WR: pat_loaded[it.addr] = 1'b1;
      CMD_PIX_Q:  n_pix++;
      default:    n_cell++;
    endcase
  endtask

  task automatic load_nt(int unsigned slot, int unsigned tile);
    fetch_item_t it = random_item(CMD_NT_WR);
    it.addr[10:0] = 11'(slot);
    it.data = 8'(tile);
    push_item(it);
  endtask

  task automatic load_pat(int unsigned a, int unsigned val);
    fetch_item_t it = random_item(CMD_PAT_WR);
    it.addr = 13'(a);
    it.data = 8'(val);
    push_item(it);
  endtask

  // Fill whatever the query will read and has never been written, then send it.
  task automatic run_query(fetch_item_t q);
    int unsigned wx, wy, slot, tile;
    query_spot(cfg, q, wx, wy);
    slot = nt_slot(cfg, wx, wy);
    if (!nt_loaded[slot]) load_nt(slot, pick_tile());
    tile = nt_shadow[slot];
    for (int i = 0; i < 16; i++)
      if ((q.cmd == CMD_CELL_Q || i % 8 == wy % 8) && !pat_loaded[pat_addr(cfg, tile, i)])
        load_pat(pat_addr(cfg, tile, i), $urandom_range(255));
    push_item(q);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits are random: the block must ignore them.
  task automatic apply_cfg(cfg_t c);
    write_reg(REG_SCROLL,   {17'($urandom), c.scroll_addr});
    write_reg(REG_FINE_X,   {29'($urandom), c.fine_x});
    write_reg(REG_MIRROR,   {30'($urandom), c.mirror});
    write_reg(REG_PAT_HIGH, {31'($urandom), c.pat_high});
    cfg = c;
  endtask

  // Sender holds off until every result is back, then lets the block settle.
  task automatic drain_and_settle(int unsigned extra);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    fetch_item_t q;
    cfg_t        c;
    int          phase_end;
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.cmd       <= '0;
    in_chan.mem_addr  <= '0;
    in_chan.mem_data  <= '0;
    in_chan.pixel_x   <= '0;
    in_chan.pixel_row <= '0;
    in_chan.cell_col  <= '0;
    in_chan.cell_row  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    c = '0;
    apply_cfg(c);

    // nametable write with address bits 12:11 set lands on the top slot
    q = random_item(CMD_NT_WR);
    q.addr = 13'h1FFF;
    q.data = 8'hFF;
    push_item(q);
    q.addr = 13'h0000;
    q.data = 8'h00;
    push_item(q);
    q = random_item(CMD_PAT_WR);
    q.addr = 13'h1FFF;
    q.data = 8'hFF;
    push_item(q);
    q.addr = 13'h0000;
    q.data = 8'h00;
    push_item(q);

    // corners, last visible row and rows past the visible area
    for (int i = 0; i < 6; i++) begin
      q = random_item(CMD_PIX_Q);
      q.px   = (i % 2) ? 8'd255 : 8'd0;
      q.prow = (i < 2) ? 8'd0 : (i < 4) ? 8'd231 : 8'd255;
      run_query(q);
    end
    for (int i = 0; i < 4; i++) begin
      q = random_item(CMD_CELL_Q);
      q.ccol = (i % 2) ? 5'd31 : 5'd0;
      q.crow = (i < 2) ? 5'd0 : (i == 2) ? 5'd28 : 5'd31;
      run_query(q);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_and_settle(24);
      c.scroll_addr = 15'($urandom);
      c.fine_x      = 3'($urandom);
      c.mirror      = mirror_t'(ph % 4);
      c.pat_high    = ph[1];
      case (ph)
        0: begin
          c.scroll_addr = '0;
          c.fine_x      = '0;
        end
        1: c.scroll_addr[9:5] = 5'd30;
        3: begin
          c.scroll_addr = '1;
          c.fine_x      = '1;
        end
        default: ;
      endcase
      apply_cfg(c);
      case ((ph + ph / 4) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase

      phase_end = n_items + 90;
      while (n_items < phase_end) begin
        case ($urandom_range(9))
          0, 1, 2, 3: run_query(random_item(CMD_PIX_Q));
          4, 5:       run_query(random_item(CMD_CELL_Q));
          6, 7: begin
            q = random_item(CMD_NT_WR);
            q.data = 8'(pick_tile());
            push_item(q);
          end
          default:    push_item(random_item(CMD_PAT_WR));
        endcase
      end
    end

    drain_and_settle(40);
    $display("%0d items sent: %0d pixel queries, %0d cell queries, the rest RAM writes",
             n_items, n_pix, n_cell);
    $display("%0d results compared across 8 scroll/mirroring setups and 4 flow-control mixes",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("PASS scrolled_tile_background_fetch");
    end else begin
      $display("FAIL scrolled_tile_background_fetch");
    end
    $finish;
  end

endmodule
